[src/kta_pkg.sv]
// Shared types, constants and register indexes of the kinetic temperature accumulator.
// Depends on nothing; every other file of the block but kta_ram imports it.
package kta_pkg;

  localparam int NUM_TYPES_DEF = 16;
  localparam int ACC_WIDTH_DEF = 64;

  localparam int VEL_W     = 24;
  localparam int MASS_W    = 24;
  localparam int MASS_HW   = MASS_W / 2;
  localparam int TYPE_W    = 4;
  localparam int MASK_W    = 32;
  localparam int FACTOR_W  = 32;
  localparam int OUT_W     = 64;
  localparam int NUM_SUMS  = 6;
  localparam int TERM_SHIFT  = 28;
  localparam int SCALE_SHIFT = 16;

  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BIT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ATOM_MASS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FACTOR   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_FACTOR = 8'd3;

  localparam logic [MASK_W-1:0]   GROUP_BIT_RST     = 32'd1;
  localparam logic                USE_ATOM_MASS_RST = 1'b0;
  localparam logic [FACTOR_W-1:0] TEMP_FACTOR_RST   = 32'd0;
  localparam logic [FACTOR_W-1:0] ENERGY_FACTOR_RST = 32'd65536;

  // Meaning of the action field.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic [MASK_W-1:0]   group_bit;
    logic                use_atom_mass;
    logic [FACTOR_W-1:0] temp_factor;
    logic [FACTOR_W-1:0] energy_factor;
  } cfg_t;

  typedef struct packed {
    logic                    action;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [TYPE_W-1:0]       atom_type;
    logic [MASS_W-1:0]       atom_mass;
    logic [MASK_W-1:0]       atom_mask;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] temperature;
    logic signed [OUT_W-1:0] sum_xx;
    logic signed [OUT_W-1:0] sum_yy;
    logic signed [OUT_W-1:0] sum_zz;
    logic signed [OUT_W-1:0] sum_xy;
    logic signed [OUT_W-1:0] sum_xz;
    logic signed [OUT_W-1:0] sum_yz;
    logic                    overflow;
  } result_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ACCUM,
    OP_SKIP
  } op_e;

  // One classified beat as it waits between the front and the back.
  typedef struct packed {
    op_e                     op;
    logic                    last;
    logic                    type_ok;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [TYPE_W-1:0]       atom_type;
    logic [MASS_W-1:0]       atom_mass;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MASS,
    ST_VV,
    ST_VM,
    ST_ADD,
    ST_TRACE,
    ST_WAIT_OUT,
    ST_SMUL,
    ST_SFIX,
    ST_DONE
  } state_e;

endpackage

[src/kta_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kta_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/kta_front.sv]
// Front end: accepts input beats, classifies them and holds them in a short queue.
// Depends on kta_pkg.
module kta_front #(
  parameter int NUM_TYPES = kta_pkg::NUM_TYPES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kta_pkg::cfg_t  cfg_i,
  input  logic           push,
  output logic           full,
  input  kta_pkg::item_t in_data_i,
  output logic           q_valid_o,
  output kta_pkg::entry_t q_entry_o,
  input  logic           q_pop_i
);
  import kta_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  entry_t         entries_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  entry_t         new_entry;
  logic           do_push;
  logic           do_pop;

  // Classification: out-of-range loads and unselected atoms only keep their last flag.
  always_comb begin
    new_entry.last      = in_data_i.last;
    new_entry.type_ok   = 32'(in_data_i.atom_type) < NUM_TYPES;
    new_entry.vel_x     = in_data_i.vel_x;
    new_entry.vel_y     = in_data_i.vel_y;
    new_entry.vel_z     = in_data_i.vel_z;
    new_entry.atom_type = in_data_i.atom_type;
    new_entry.atom_mass = in_data_i.atom_mass;
    if (in_data_i.action == ACT_LOAD) begin
      new_entry.op = new_entry.type_ok ? OP_LOAD : OP_SKIP;
    end else if ((in_data_i.atom_mask & cfg_i.group_bit) != '0) begin
      new_entry.op = OP_ACCUM;
    end else begin
      new_entry.op = OP_SKIP;
    end
  end

  assign full      = (count_q == QCW'(QUEUE_DEPTH));
  assign q_valid_o = (count_q != '0);
  assign q_entry_o = entries_q[rd_ptr_q];
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

[src/kta_back.sv]
// Back end: mass lookup, tensor accumulation, trace and scaling, and the result register.
// Depends on kta_pkg and kta_ram.
module kta_back #(
  parameter int NUM_TYPES = kta_pkg::NUM_TYPES_DEF,
  parameter int ACC_WIDTH = kta_pkg::ACC_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kta_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  kta_pkg::entry_t  q_entry_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output kta_pkg::result_t out_data_o
);
  import kta_pkg::*;

  localparam int AW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int VV_W  = 2 * VEL_W;
  localparam int PM_W  = VV_W + MASS_HW + 1;
  localparam int FULL_W = PM_W + MASS_HW;
  localparam int TERM_W = FULL_W - TERM_SHIFT;
  localparam int PW    = ACC_WIDTH + FACTOR_W + 1;

  function automatic logic [ACC_WIDTH:0] sat_add(input logic signed [ACC_WIDTH-1:0] a,
                                                 input logic signed [ACC_WIDTH-1:0] b);
    logic signed [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return {1'b1, s[ACC_WIDTH], {(ACC_WIDTH-1){~s[ACC_WIDTH]}}};
    end
    return {1'b0, s[ACC_WIDTH-1:0]};
  endfunction

  state_e state_q, state_d;
  logic [2:0] idx_q, idx_d;
  entry_t cur_q, cur_d;
  logic [MASS_W-1:0] mass_q, mass_d;
  logic signed [ACC_WIDTH-1:0] tr_q, tr_d;
  logic signed [ACC_WIDTH-1:0] sums_q [NUM_SUMS];
  logic signed [ACC_WIDTH-1:0] sums_d [NUM_SUMS];
  logic flag_q, flag_d;
  result_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic signed [VV_W-1:0]      vv_q;
  logic signed [PM_W-1:0]      pa_q, pb_q;
  logic [2*FACTOR_W-1:0]       plo_q;
  logic signed [ACC_WIDTH:0]   phi_q;

  logic [2:0]                  rd_idx;
  logic signed [ACC_WIDTH-1:0] sum_rd;
  logic signed [VEL_W-1:0]     op_a, op_b;
  logic signed [VV_W-1:0]      vv_d;
  logic signed [PM_W-1:0]      pa_d, pb_d;
  logic signed [FULL_W-1:0]    term_full;
  logic signed [TERM_W-1:0]    term;
  logic [ACC_WIDTH:0]          acc_res;
  logic [ACC_WIDTH:0]          tr_res;
  logic signed [ACC_WIDTH-1:0] sc_a;
  logic [FACTOR_W-1:0]         sc_f;
  logic [2*FACTOR_W-1:0]       plo_d;
  logic signed [ACC_WIDTH:0]   phi_d;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        prod_sh;
  logic                        sc_in_range;
  logic signed [ACC_WIDTH-1:0] sc_val;

  logic              ram_we;
  logic [MASS_W-1:0] ram_rdata;

  kta_ram #(
    .WIDTH(MASS_W),
    .DEPTH(NUM_TYPES)
  ) u_mass_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(q_entry_i.atom_type)),
    .wdata_i(q_entry_i.atom_mass),
    .raddr_i(AW'(q_entry_i.atom_type)),
    .rdata_o(ram_rdata)
  );

  // The six tensor components, in sum order xx, yy, zz, xy, xz, yz.
  always_comb begin
    case (idx_q)
      3'd0: begin op_a = cur_q.vel_x; op_b = cur_q.vel_x; end
      3'd1: begin op_a = cur_q.vel_y; op_b = cur_q.vel_y; end
      3'd2: begin op_a = cur_q.vel_z; op_b = cur_q.vel_z; end
      3'd3: begin op_a = cur_q.vel_x; op_b = cur_q.vel_y; end
      3'd4: begin op_a = cur_q.vel_x; op_b = cur_q.vel_z; end
      3'd5: begin op_a = cur_q.vel_y; op_b = cur_q.vel_z; end
      default: begin op_a = cur_q.vel_x; op_b = cur_q.vel_x; end
    endcase
  end

  assign sum_rd = sums_q[rd_idx];
  assign vv_d   = op_a * op_b;
  assign pa_d   = vv_q * $signed({1'b0, mass_q[MASS_W-1:MASS_HW]});
  assign pb_d   = vv_q * $signed({1'b0, mass_q[MASS_HW-1:0]});

  // Exact m*vi*vj, then an arithmetic shift gives the floor.
  assign term_full = (FULL_W'(pa_q) <<< MASS_HW) + FULL_W'(pb_q);
  assign term      = term_full[FULL_W-1:TERM_SHIFT];
  assign acc_res   = sat_add(sum_rd, ACC_WIDTH'(term));
  assign tr_res    = sat_add(tr_q, sum_rd);

  // Scaling: the operand is split at bit 32 so that each partial product multiplies a 32-bit part of it by the factor.
  assign sc_a  = (idx_q == 3'd0) ? tr_q : sum_rd;
  assign sc_f  = (idx_q == 3'd0) ? cfg_i.temp_factor : cfg_i.energy_factor;
  assign plo_d = (2*FACTOR_W)'(sc_a[31:0]) * (2*FACTOR_W)'(sc_f);
  assign phi_d = $signed(sc_a[ACC_WIDTH-1:32]) * $signed({1'b0, sc_f});

  assign prod        = (PW'(phi_q) <<< 32) + $signed(PW'(plo_q));
  assign prod_sh     = prod >>> SCALE_SHIFT;
  assign sc_in_range = (&prod_sh[PW-1:ACC_WIDTH-1]) || !(|prod_sh[PW-1:ACC_WIDTH-1]);
  assign sc_val      = sc_in_range ? prod_sh[ACC_WIDTH-1:0]
                                   : {prod_sh[PW-1], {(ACC_WIDTH-1){~prod_sh[PW-1]}}};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    mass_d      = mass_q;
    tr_d        = tr_q;
    sums_d      = sums_q;
    flag_d      = flag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    rd_idx      = idx_q;

    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          idx_d   = '0;
          case (q_entry_i.op)
            OP_LOAD: begin
              ram_we  = 1'b1;
              state_d = q_entry_i.last ? ST_TRACE : ST_IDLE;
            end
            OP_ACCUM: begin
              if (cfg_i.use_atom_mass) begin
                mass_d  = q_entry_i.atom_mass;
                state_d = ST_VV;
              end else begin
                state_d = ST_MASS;
              end
            end
            default: begin
              state_d = q_entry_i.last ? ST_TRACE : ST_IDLE;
            end
          endcase
        end
      end
      ST_MASS: begin
        mass_d  = cur_q.type_ok ? ram_rdata : '0;
        state_d = ST_VV;
      end
      ST_VV: begin
        state_d = ST_VM;
      end
      ST_VM: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        sums_d[idx_q] = acc_res[ACC_WIDTH-1:0];
        flag_d        = flag_q | acc_res[ACC_WIDTH];
        if (idx_q == 3'(NUM_SUMS - 1)) begin
          idx_d   = '0;
          state_d = cur_q.last ? ST_TRACE : ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_VV;
        end
      end
      ST_TRACE: begin
        if (idx_q == 3'd0) begin
          tr_d = sum_rd;
        end else begin
          tr_d   = tr_res[ACC_WIDTH-1:0];
          flag_d = flag_q | tr_res[ACC_WIDTH];
        end
        if (idx_q == 3'd2) begin
          idx_d   = '0;
          state_d = ST_WAIT_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_WAIT_OUT: begin
        if (!out_valid_q) begin
          state_d = ST_SMUL;
        end
      end
      ST_SMUL: begin
        rd_idx  = (idx_q == 3'd0) ? 3'd0 : idx_q - 1'b1;
        state_d = ST_SFIX;
      end
      ST_SFIX: begin
        flag_d = flag_q | !sc_in_range;
        case (idx_q)
          3'd0: out_d.temperature = OUT_W'(sc_val);
          3'd1: out_d.sum_xx      = OUT_W'(sc_val);
          3'd2: out_d.sum_yy      = OUT_W'(sc_val);
          3'd3: out_d.sum_zz      = OUT_W'(sc_val);
          3'd4: out_d.sum_xy      = OUT_W'(sc_val);
          3'd5: out_d.sum_xz      = OUT_W'(sc_val);
          3'd6: out_d.sum_yz      = OUT_W'(sc_val);
          default: out_d = out_q;
        endcase
        if (idx_q == 3'(NUM_SUMS)) begin
          idx_d   = '0;
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SMUL;
        end
      end
      ST_DONE: begin
        out_d.overflow = flag_q;
        out_valid_d    = 1'b1;
        flag_d         = 1'b0;
        for (int i = 0; i < NUM_SUMS; i++) begin
          sums_d[i] = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SUMS; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      sums_q      <= sums_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    mass_q <= mass_d;
    tr_q   <= tr_d;
    out_q  <= out_d;
    if (state_q == ST_VV) begin
      vv_q <= vv_d;
    end
    if (state_q == ST_VM) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (state_q == ST_SMUL) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

endmodule

[src/kinetic_temperature_accumulator.sv]
// Top level of the kinetic energy tensor and temperature accumulator.
// Depends on kta_pkg, kta_front, kta_back and kta_ram.

// The block sums m*vi*vj over a stream of atom beats for the six tensor components
// (xx, yy, zz, xy, xz, yz) into saturating signed accumulators, and on a beat with last
// set it delivers one result: the trace times temp_factor and the six sums times
// energy_factor, all signed Q48.16, with an overflow bit that is set if any
// accumulation, the trace or a scaling clamped since the previous result. Input beats
// go into a two-entry queue, so pushes are taken while the back end works and while a
// finished result waits to be popped, until the queue is full. The back end handles one
// beat at a time: a mass load or a beat that is not in the group is done in the idle
// state; a counted atom first takes a table read when the per-atom mass is off, then
// the VV, VM and ADD states for each of the six components through one shared
// multiply and accumulate path; a beat with last adds the trace, a wait while the
// previous result is unpopped, the seven scalings and the result handover. Mass table
// entries are not cleared by reset; an atom must not use a type whose entry was never
// loaded. Configuration writes are always taken and must only be issued while the
// block is idle.
module kinetic_temperature_accumulator #(
  parameter int NUM_TYPES = kta_pkg::NUM_TYPES_DEF,
  parameter int ACC_WIDTH = kta_pkg::ACC_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kta_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kta_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  kta_pkg::item_t                     in_data_i,
  output logic                               empty,
  input  logic                               pop,
  output kta_pkg::result_t                   out_data_o
);
  import kta_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  // The configuration channel never stalls; a write to an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GROUP_BIT:     cfg_d.group_bit     = cfg_wdata_i;
        CFG_USE_ATOM_MASS: cfg_d.use_atom_mass = cfg_wdata_i[0];
        CFG_TEMP_FACTOR:   cfg_d.temp_factor   = cfg_wdata_i;
        CFG_ENERGY_FACTOR: cfg_d.energy_factor = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.group_bit     <= GROUP_BIT_RST;
      cfg_q.use_atom_mass <= USE_ATOM_MASS_RST;
      cfg_q.temp_factor   <= TEMP_FACTOR_RST;
      cfg_q.energy_factor <= ENERGY_FACTOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: group filter, table range check and the beat queue.
  kta_front #(
    .NUM_TYPES(NUM_TYPES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push     (push),
    .full     (full),
    .in_data_i(in_data_i),
    .q_valid_o(q_valid),
    .q_entry_o(q_entry),
    .q_pop_i  (q_pop)
  );

  // Back end: mass table, accumulation, scaling and the result register.
  kta_back #(
    .NUM_TYPES(NUM_TYPES),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

endmodule

[bench/testbench.sv]
// Self-checking testbench for kinetic_temperature_accumulator.
// Depends on kta_pkg and the block's RTL; it predicts each readout and checks it field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kta_pkg::*;

  // Run length and watchdog.
  localparam int RANDOM_BEATS = 800;
  localparam int DRAIN_CYCLES = 128;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ACC_W        = ACC_WIDTH_DEF;

  // Register indexes that the block does not implement; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

  localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;

  // Clock, reset and every block input start at known values.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  push        = 1'b0;
  item_t                 in_data     = '0;
  logic                  pop         = 1'b0;
  logic                  cfg_ready;
  logic                  full;
  logic                  empty;
  result_t               out_data;

  // Mirror of the block's configuration registers.
  logic [MASK_W-1:0]   cfg_group;
  logic                cfg_use_atom_mass;
  logic [FACTOR_W-1:0] cfg_temp_factor;
  logic [FACTOR_W-1:0] cfg_energy_factor;

  // Mirror of the block's state: mass table, the six tensor sums and the clamp flag.
  logic [MASS_W-1:0]    mass_mirror [NUM_TYPES_DEF];
  bit                   loaded      [NUM_TYPES_DEF];
  logic signed [63:0]   tensor      [NUM_SUMS];
  bit                   clamp_seen;

  result_t predicted_readouts [$];
  int      mismatches   = 0;
  int      beats_sent   = 0;
  int      cycle_count  = 0;
  int      pop_hold     = 0;
  bit      no_idle      = 1'b0;

  kinetic_temperature_accumulator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction. All arithmetic is done at 128 bits, where every intermediate
  // is exact, and then clamped to the signed accumulator range.
  // ---------------------------------------------------------------------------

  // Clamp to the signed ACC_W range and remember that a clamp happened.
  function automatic logic signed [63:0] clamp_acc(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (ACC_W - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) begin
      clamp_seen = 1'b1;
      return hi[63:0];
    end
    if (v < lo) begin
      clamp_seen = 1'b1;
      return lo[63:0];
    end
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] acc,
                                                 input logic signed [63:0] t);
    logic signed [127:0] wa;
    logic signed [127:0] wt;
    wa = 128'(acc);
    wt = 128'(t);
    return clamp_acc(wa + wt);
  endfunction

  // m * vi * vj is Q28.44; the arithmetic shift by 28 rounds toward minus infinity.
  function automatic logic signed [63:0] mass_term(input logic signed [VEL_W-1:0] vi,
                                                   input logic signed [VEL_W-1:0] vj,
                                                   input logic [MASS_W-1:0] m);
    logic signed [127:0] wi;
    logic signed [127:0] wj;
    logic signed [127:0] wm;
    logic signed [127:0] p;
    wi = 128'(vi);
    wj = 128'(vj);
    wm = {104'd0, m};
    p  = (wi * wj * wm) >>> TERM_SHIFT;
    return p[63:0];
  endfunction

  // Q48.16 sum times Q16.16 factor, floored back to Q48.16 and clamped.
  function automatic logic signed [63:0] scale_q16(input logic signed [63:0] a,
                                                   input logic [FACTOR_W-1:0] f);
    logic signed [127:0] wa;
    logic signed [127:0] wf;
    wa = 128'(a);
    wf = {96'd0, f};
    return clamp_acc((wa * wf) >>> SCALE_SHIFT);
  endfunction

  // Folds one accepted beat into the mirrored state and queues the readout it causes.
  function automatic void accumulate_beat(input item_t b);
    logic [MASS_W-1:0]  m;
    logic signed [63:0] trace;
    result_t            r;
    if (b.action == ACT_LOAD) begin
      mass_mirror[b.atom_type] = b.atom_mass;
      loaded[b.atom_type]      = 1'b1;
    end else if ((b.atom_mask & cfg_group) != '0) begin
      m = cfg_use_atom_mass ? b.atom_mass : mass_mirror[b.atom_type];
      tensor[0] = add_sat(tensor[0], mass_term(b.vel_x, b.vel_x, m));
      tensor[1] = add_sat(tensor[1], mass_term(b.vel_y, b.vel_y, m));
      tensor[2] = add_sat(tensor[2], mass_term(b.vel_z, b.vel_z, m));
      tensor[3] = add_sat(tensor[3], mass_term(b.vel_x, b.vel_y, m));
      tensor[4] = add_sat(tensor[4], mass_term(b.vel_x, b.vel_z, m));
      tensor[5] = add_sat(tensor[5], mass_term(b.vel_y, b.vel_z, m));
    end
    if (b.last) begin
      // The trace clamps on its own, before any of the seven scalings.
      trace         = add_sat(add_sat(tensor[0], tensor[1]), tensor[2]);
      r.temperature = scale_q16(trace, cfg_temp_factor);
      r.sum_xx      = scale_q16(tensor[0], cfg_energy_factor);
      r.sum_yy      = scale_q16(tensor[1], cfg_energy_factor);
      r.sum_zz      = scale_q16(tensor[2], cfg_energy_factor);
      r.sum_xy      = scale_q16(tensor[3], cfg_energy_factor);
      r.sum_xz      = scale_q16(tensor[4], cfg_energy_factor);
      r.sum_yz      = scale_q16(tensor[5], cfg_energy_factor);
      r.overflow    = clamp_seen;
      predicted_readouts.push_back(r);
      for (int i = 0; i < NUM_SUMS; i++) tensor[i] = '0;
      clamp_seen = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Readout side: random pop stalls, and every popped beat is checked against
  // the oldest prediction.
  // ---------------------------------------------------------------------------

  // Most gaps are zero or short, a few are long; none at all while no_idle is set.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : readout_check
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_readouts.size() == 0) begin
          mismatches++;
          $display("%0t ns: readout expected none, actual %h", $time, out_data);
        end else begin
          want = predicted_readouts.pop_front();
          check_field("temperature", want.temperature, out_data.temperature);
          check_field("sum_xx", want.sum_xx, out_data.sum_xx);
          check_field("sum_yy", want.sum_yy, out_data.sum_yy);
          check_field("sum_zz", want.sum_zz, out_data.sum_zz);
          check_field("sum_xy", want.sum_xy, out_data.sum_xy);
          check_field("sum_xz", want.sum_xz, out_data.sum_xz);
          check_field("sum_yz", want.sum_yz, out_data.sum_yz);
          check_field("overflow", 64'(want.overflow), 64'(out_data.overflow));
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop      <= 1'b1;
        pop_hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Sends one beat after a random gap. Push stays high on return so that a
  // following beat can go out back to back; idle_until_drained lowers it.
  task automatic send_beat(input item_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= b;
    do @(posedge clk_i); while (full);
    accumulate_beat(b);
    beats_sent++;
  endtask

  // Stops pushing, waits for every predicted readout, then lets the back end
  // finish any beat that causes no readout, so that the block is idle.
  task automatic idle_until_drained();
    push <= 1'b0;
    while (predicted_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One configuration beat; the mirror changes only when the beat is taken.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_GROUP_BIT:     cfg_group         = data;
      CFG_USE_ATOM_MASS: cfg_use_atom_mass = data[0];
      CFG_TEMP_FACTOR:   cfg_temp_factor   = data;
      CFG_ENERGY_FACTOR: cfg_energy_factor = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t make_beat(input logic act, input logic signed [VEL_W-1:0] vx,
                                      input logic signed [VEL_W-1:0] vy,
                                      input logic signed [VEL_W-1:0] vz,
                                      input logic [TYPE_W-1:0] typ,
                                      input logic [MASS_W-1:0] mass,
                                      input logic [MASK_W-1:0] mask, input logic lst);
    item_t b;
    b.action    = act;
    b.vel_x     = vx;
    b.vel_y     = vy;
    b.vel_z     = vz;
    b.atom_type = typ;
    b.atom_mass = mass;
    b.atom_mask = mask;
    b.last      = lst;
    return b;
  endfunction

  function automatic logic signed [VEL_W-1:0] random_velocity();
    logic [VEL_W-1:0] r;
    r = VEL_W'($urandom);
    case ($urandom_range(0, 7))
      0: return VEL_MIN;
      1: return VEL_MAX;
      2: return VEL_W'($signed($urandom_range(0, 511)) - 256);
      default: return r;
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] random_mass();
    logic [MASS_W-1:0] r;
    r = MASS_W'($urandom);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return MASS_W'($urandom_range(1, 16'hFFFF));
      default: return r;
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // A random beat with random content. A counted atom that would read a table
  // entry never loaded becomes a load of that entry instead.
  function automatic item_t random_beat(input logic lst);
    item_t b;
    b = make_beat(($urandom_range(0, 99) < 15) ? ACT_LOAD : ACT_SAMPLE,
                  random_velocity(), random_velocity(), random_velocity(),
                  TYPE_W'($urandom_range(0, NUM_TYPES_DEF - 1)), random_mass(),
                  ($urandom_range(0, 3) == 0) ? $urandom : (cfg_group | $urandom), lst);
    if (b.action == ACT_SAMPLE && !cfg_use_atom_mass && (b.atom_mask & cfg_group) != '0 &&
        !loaded[b.atom_type])
      b.action = ACT_LOAD;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Table loads at the mass extremes; the load that carries last reads out zeros.
  task automatic test_mass_loads();
    send_beat(make_beat(ACT_LOAD, '0, '0, '0, 4'd0, '1, '0, 1'b0));
    send_beat(make_beat(ACT_LOAD, '1, '1, '1, 4'd15, '0, '1, 1'b0));
    send_beat(make_beat(ACT_LOAD, '0, '0, '0, 4'd5, 24'h001000, '0, 1'b1));
    idle_until_drained();
  endtask

  // Velocity extremes through the table masses under the reset configuration.
  task automatic test_velocity_extremes();
    send_beat(make_beat(ACT_SAMPLE, VEL_MIN, VEL_MIN, VEL_MIN, 4'd0, '0, '1, 1'b0));
    send_beat(make_beat(ACT_SAMPLE, VEL_MAX, VEL_MAX, VEL_MAX, 4'd5, '1, 32'd1, 1'b0));
    send_beat(make_beat(ACT_SAMPLE, VEL_MIN, VEL_MAX, '0, 4'd0, '0, 32'd3, 1'b0));
    send_beat(make_beat(ACT_SAMPLE, VEL_MAX, VEL_MIN, '1, 4'd15, '1, 32'd1, 1'b1));
    idle_until_drained();
  endtask

  // Group selection at the top bit and with nothing selected; it ends with every group bit set.
  task automatic test_group_filter();
    write_register(CFG_GROUP_BIT, 32'h8000_0000);
    write_register(CFG_TEMP_FACTOR, 32'h0001_0000);
    // An atom outside the group that carries last still reads out.
    send_beat(make_beat(ACT_SAMPLE, VEL_MAX, VEL_MAX, VEL_MAX, 4'd0, '0, 32'h7FFF_FFFF, 1'b1));
    send_beat(make_beat(ACT_SAMPLE, VEL_MIN, 24'sd3, -24'sd7, 4'd0, '0, 32'h8000_0000, 1'b0));
    send_beat(make_beat(ACT_SAMPLE, 24'sd65536, VEL_MAX, VEL_MIN, 4'd5, '0, '1, 1'b1));
    idle_until_drained();
    write_register(CFG_GROUP_BIT, '0);
    send_beat(make_beat(ACT_SAMPLE, VEL_MIN, VEL_MIN, VEL_MIN, 4'd0, '0, '1, 1'b1));
    idle_until_drained();
    write_register(CFG_GROUP_BIT, '1);
  endtask

  // Per-atom masses with the factors at both extremes, floor rounding of a
  // tiny negative cross term, and writes to indexes that do not exist.
  task automatic test_atom_mass();
    write_register(CFG_USE_ATOM_MASS, '1);
    write_register(CFG_TEMP_FACTOR, '1);
    write_register(CFG_ENERGY_FACTOR, '1);
    write_register(CFG_UNUSED_LOW, '0);
    write_register(CFG_UNUSED_HIGH, '0);
    send_beat(make_beat(ACT_SAMPLE, VEL_MIN, VEL_MIN, VEL_MIN, 4'd9, '1, 32'd1, 1'b0));
    send_beat(make_beat(ACT_SAMPLE, VEL_MAX, VEL_MIN, VEL_MAX, 4'd3, '0, 32'd1, 1'b0));
    send_beat(make_beat(ACT_SAMPLE, 24'sd1, -24'sd1, 24'sd1, 4'd12, 24'd1, 32'd1, 1'b1));
    idle_until_drained();
    // Only bit zero of the mass source register counts.
    write_register(CFG_USE_ATOM_MASS, 32'hFFFF_FFFE);
    write_register(CFG_TEMP_FACTOR, '0);
    write_register(CFG_ENERGY_FACTOR, '0);
    send_beat(make_beat(ACT_SAMPLE, VEL_MAX, VEL_MAX, VEL_MAX, 4'd0, '1, 32'd1, 1'b1));
    idle_until_drained();
  endtask

  // Phases of random configuration, each a few atom sets that end with last.
  // A rare early last breaks a set in two.
  task automatic test_random_stream();
    int target;
    int sets;
    int len;
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      idle_until_drained();
      no_idle = ($urandom_range(0, 3) == 0);
      write_register(CFG_GROUP_BIT, ($urandom_range(0, 9) == 0) ? '0 : random_word());
      write_register(CFG_USE_ATOM_MASS, $urandom);
      write_register(CFG_TEMP_FACTOR, random_word());
      write_register(CFG_ENERGY_FACTOR, ($urandom_range(0, 2) == 0) ? 32'h0001_0000
                                                                     : random_word());
      if ($urandom_range(0, 9) == 0)
        write_register(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
      sets = $urandom_range(1, 6);
      for (int s = 0; s < sets; s++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_beat(random_beat(k == len - 1 || $urandom_range(0, 99) < 3));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    cfg_group         = GROUP_BIT_RST;
    cfg_use_atom_mass = USE_ATOM_MASS_RST;
    cfg_temp_factor   = TEMP_FACTOR_RST;
    cfg_energy_factor = ENERGY_FACTOR_RST;
    for (int i = 0; i < NUM_TYPES_DEF; i++) begin
      mass_mirror[i] = '0;
      loaded[i]      = 1'b0;
    end
    for (int i = 0; i < NUM_SUMS; i++) tensor[i] = '0;
    clamp_seen = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mass_loads();
    test_velocity_extremes();
    test_group_filter();
    test_atom_mass();
    test_random_stream();

    // Nothing may be left waiting, and nothing extra may appear afterwards.
    idle_until_drained();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
